// ----- hw/rtl/olir_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olir_pkg
// Shared types and codes for the ordered list with insert and remove.
// ----------------------------------------------------------------------------
package olir_pkg;

    localparam int DATA_W    = 32;
    localparam int POS_W     = 5;
    localparam int LEN_W     = 5;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int DEF_DEPTH = 16;
    localparam int MAX_DEPTH = 256;
    // wide enough for any index or length up to MAX_DEPTH
    localparam int IDX_W     = $clog2(MAX_DEPTH + 1);

    localparam int S_TDATA_W = ((DATA_W + POS_W + 7) / 8) * 8;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = ((DATA_W + LEN_W + STATUS_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND      = 2'd0,
        CMD_REMOVE_LAST = 2'd1,
        CMD_INSERT      = 2'd2,
        CMD_REMOVE_AT   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE
    } cell_op_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t                  op;
        logic [IDX_W-1:0]          target;
        logic signed [DATA_W-1:0]  word;
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/olir_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olir_cell
// One list slot: holds a word, takes the word of a neighbour on a shift,
// and offers its word when it is the slot being removed.
// ----------------------------------------------------------------------------
module olir_cell #(
    parameter int INDEX = 0
) (
    input  logic                                  aclk,
    input  olir_pkg::cell_ctrl_t                  ctrl,
    input  logic signed [olir_pkg::DATA_W-1:0]    left_value,
    input  logic signed [olir_pkg::DATA_W-1:0]    right_value,
    output logic signed [olir_pkg::DATA_W-1:0]    value,
    output logic signed [olir_pkg::DATA_W-1:0]    removed_part
);
    import olir_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        case (ctrl.op)
            OP_INSERT: begin
                if (MY_IDX == ctrl.target) begin
                    value_next = ctrl.word;
                end else if (MY_IDX > ctrl.target) begin
                    value_next = left_value;
                end
            end
            OP_REMOVE: begin
                if (MY_IDX >= ctrl.target) begin
                    value_next = right_value;
                end
            end
            default: value_next = value_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value        = value_reg;
    // zero unless this slot is the one taken out, so the parts can be ORed
    assign removed_part = (ctrl.op == OP_REMOVE && MY_IDX == ctrl.target) ?
                          value_reg : '0;

endmodule

// ----- hw/rtl/ordered_list_insert_remove.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_insert_remove
// Bounded ordered list of signed words with append, remove last, insert and
// remove at a position.
// ----------------------------------------------------------------------------
// The list is a chain of DEPTH cells; an insert or a remove moves every later
// entry one cell in the same cycle. The result is offered in the cycle after
// the command transfer. A new command can be accepted in any cycle in which
// the output register is empty or its result is being taken; a result left
// waiting holds the input until it is taken. Each command gives one result
// transfer with the removed word, the new length (low five bits) and a status;
// a failed command leaves the list unchanged. No clearing pass is needed after
// reset: only the entry count and the output valid flag are cleared.
module ordered_list_insert_remove #(
    parameter int DEPTH = olir_pkg::DEF_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // data_value [31:0], position [36:32], zero pad [39:37]
    input  logic [olir_pkg::S_TDATA_W-1:0]    s_tdata,
    // command [1:0]
    input  logic [olir_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // removed_value [31:0], length [36:32], status [38:37], zero pad [39]
    output logic [olir_pkg::M_TDATA_W-1:0]    m_tdata
);
    import olir_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(DEPTH);

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] m_removed_reg;
    logic [LEN_W-1:0]         m_length_reg;
    status_t                  m_status_reg;

    logic                     s_fire;
    cmd_t                     cmd;
    logic signed [DATA_W-1:0] word;
    logic [IDX_W-1:0]         pos_ext;
    logic [IDX_W-1:0]         cnt_ext;
    logic [IDX_W-1:0]         cnt_next_ext;
    status_t                  status;
    cell_ctrl_t               ctrl;
    logic signed [DATA_W-1:0] removed;

    logic signed [DATA_W-1:0] cell_value [DEPTH];
    logic signed [DATA_W-1:0] cell_part  [DEPTH];

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tuser[CMD_W-1:0]);
    assign word     = s_tdata[DATA_W-1:0];
    assign pos_ext  = IDX_W'(s_tdata[DATA_W +: POS_W]);
    assign cnt_ext  = IDX_W'(count_reg);

    always_comb begin
        status      = ST_OK;
        ctrl.op     = OP_HOLD;
        ctrl.target = pos_ext;
        ctrl.word   = word;
        case (cmd)
            CMD_APPEND: begin
                ctrl.target = cnt_ext;
                if (cnt_ext >= DEPTH_IDX) begin
                    status = ST_FULL;
                end else begin
                    ctrl.op = OP_INSERT;
                end
            end
            CMD_REMOVE_LAST: begin
                ctrl.target = cnt_ext - IDX_W'(1);
                if (cnt_ext == '0) begin
                    status = ST_EMPTY;
                end else begin
                    ctrl.op = OP_REMOVE;
                end
            end
            CMD_INSERT: begin
                if (cnt_ext >= DEPTH_IDX) begin
                    status = ST_FULL;
                end else if (pos_ext > cnt_ext) begin
                    status = ST_RANGE;
                end else begin
                    ctrl.op = OP_INSERT;
                end
            end
            CMD_REMOVE_AT: begin
                if (cnt_ext == '0) begin
                    status = ST_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    status = ST_RANGE;
                end else begin
                    ctrl.op = OP_REMOVE;
                end
            end
            default: status = ST_OK;
        endcase
        // no shift unless the command is actually transferred
        if (!s_fire) begin
            ctrl.op = OP_HOLD;
        end
    end

    always_comb begin
        count_next = count_reg;
        case (ctrl.op)
            OP_INSERT: count_next = count_reg + CNT_W'(1);
            OP_REMOVE: count_next = count_reg - CNT_W'(1);
            default:   count_next = count_reg;
        endcase
    end

    assign cnt_next_ext = IDX_W'(count_next);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic signed [DATA_W-1:0] left_w;
            logic signed [DATA_W-1:0] right_w;
            if (gi == 0) begin : g_first
                assign left_w = cell_value[gi];
            end else begin : g_mid_l
                assign left_w = cell_value[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign right_w = cell_value[gi];
            end else begin : g_mid_r
                assign right_w = cell_value[gi+1];
            end
            olir_cell #(
                .INDEX (gi)
            ) u_cell (
                .aclk         (aclk),
                .ctrl         (ctrl),
                .left_value   (left_w),
                .right_value  (right_w),
                .value        (cell_value[gi]),
                .removed_part (cell_part[gi])
            );
        end
    endgenerate

    // at most one cell offers a non-zero part
    always_comb begin
        removed = '0;
        for (int i = 0; i < DEPTH; i++) begin
            removed = removed | cell_part[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_removed_reg <= removed;
            m_length_reg  <= cnt_next_ext[LEN_W-1:0];
            m_status_reg  <= status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_status_reg, m_length_reg, m_removed_reg});

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        IDX_W'(count_reg) <= DEPTH_IDX)
        else $error("entry count above depth");

    a_fail_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && status != ST_OK) |=> $stable(count_reg))
        else $error("failed command changed the length");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == ST_EMPTY) |->
        (m_length_reg == '0 && m_removed_reg == '0))
        else $error("empty status with non-zero length or word");

    a_full_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == ST_FULL) |->
        (m_length_reg == DEPTH_IDX[LEN_W-1:0]))
        else $error("full status without a full list");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_tready)
        else $error("input stalled with empty output register");

endmodule

// ----- test/olir_list_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olir_list_checker
// Watches both stream channels of the ordered list and checks every result.
// ----------------------------------------------------------------------------
// Every command transfer on the slave side is run through a shadow copy of
// the list, and the result it should give is queued. Every transfer on the
// master side is compared field by field with the oldest queued result.
// Mismatches and results that nobody asked for are counted.
module olir_list_checker #(
    parameter int DEPTH = olir_pkg::DEF_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // data_value [31:0], position [36:32], zero pad [39:37]
    input  logic [olir_pkg::S_TDATA_W-1:0] s_tdata,
    // command [1:0]
    input  logic [olir_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // removed_value [31:0], length [36:32], status [38:37], zero pad [39]
    input  logic [olir_pkg::M_TDATA_W-1:0] m_tdata,
    output int                             fail_count,
    output int                             results_awaited
);
    import olir_pkg::*;

    typedef struct {
        logic signed [DATA_W-1:0] removed_value;
        logic [LEN_W-1:0]         length;
        status_t                  status;
    } list_result_t;

    logic signed [DATA_W-1:0] shadow_words [DEPTH];
    int                       shadow_count = 0;
    list_result_t             expected_results [$];
    int                       mismatches = 0;

    // Carry out one command on the shadow list and return what it reports.
    function automatic list_result_t apply_list_command(
        input cmd_t                     cmd,
        input logic signed [DATA_W-1:0] word,
        input logic [POS_W-1:0]         pos
    );
        list_result_t res;
        int           at;
        res.removed_value = '0;
        res.status        = ST_OK;
        at                = int'(pos);
        case (cmd)
            CMD_APPEND: begin
                if (shadow_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_words[shadow_count] = word;
                    shadow_count++;
                end
            end
            CMD_REMOVE_LAST: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    shadow_count--;
                    res.removed_value = shadow_words[shadow_count];
                end
            end
            CMD_INSERT: begin
                // full takes precedence over a bad position
                if (shadow_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else if (at > shadow_count) begin
                    res.status = ST_RANGE;
                end else begin
                    for (int i = shadow_count; i > at; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[at] = word;
                    shadow_count++;
                end
            end
            default: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (at >= shadow_count) begin
                    res.status = ST_RANGE;
                end else begin
                    res.removed_value = shadow_words[at];
                    for (int i = at; i + 1 < shadow_count; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_count--;
                end
            end
        endcase
        res.length = shadow_count[LEN_W-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        list_result_t want;
        list_result_t got;
        if (!aresetn) begin
            shadow_count = 0;
            expected_results.delete();
        end else begin
            // queue before comparing, so a same-edge result would still line up
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_list_command(cmd_t'(s_tuser),
                                           s_tdata[DATA_W-1:0],
                                           s_tdata[DATA_W +: POS_W]));
            if (m_tvalid && m_tready) begin
                got.removed_value = m_tdata[DATA_W-1:0];
                got.length        = m_tdata[DATA_W +: LEN_W];
                got.status        = status_t'(m_tdata[DATA_W + LEN_W +: STATUS_W]);
                if (expected_results.size() == 0) begin
                    $error("unexpected result transfer: removed_value %0d length %0d status %0d",
                           got.removed_value, got.length, got.status);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.removed_value !== want.removed_value) begin
                        $error("removed_value: expected %0d, got %0d",
                               want.removed_value, got.removed_value);
                        mismatches++;
                    end
                    if (got.length !== want.length) begin
                        $error("length: expected %0d, got %0d", want.length, got.length);
                        mismatches++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatches++;
                    end
                end
            end
        end
        results_awaited <= expected_results.size();
        fail_count      <= mismatches;
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the ordered list with insert and remove.
// ----------------------------------------------------------------------------
// A short directed sequence walks through the empty, full and bad-position
// cases, then random commands follow in phases that favour growing,
// shrinking or churning the list, so that it fills and drains many times.
// The sender works in bursts with gaps; the receiver stalls in patterns of
// its own. Results are checked by olir_list_checker.
module tb_top;
    import olir_pkg::*;

    localparam int                   DEPTH        = DEF_DEPTH;
    localparam int                   RANDOM_ITEMS = 550;
    localparam int                   CYCLE_LIMIT  = 200000;
    localparam int                   DRAIN_CYCLES = 20;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

    typedef enum {MIX_GROW, MIX_SHRINK, MIX_CHURN} mix_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int fail_count;
    int results_awaited;
    int cycle_count = 0;
    int burst_left  = 1;
    int list_len    = 0;   // length the list will have once all sent commands land
    int stall_mode  = 0;
    int stall_left  = 0;

    ordered_list_insert_remove #(.DEPTH(DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    olir_list_checker #(.DEPTH(DEPTH)) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .results_awaited (results_awaited)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: free-flowing, light stalls, heavy stalls or strict toggling.
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ($urandom_range(0, 9) < 3);
            default: m_tready <= ~m_tready;
        endcase
    end

    // Hold the command until it is taken, then track the length and idle
    // once the current burst is used up.
    task automatic send_cmd(input cmd_t cmd, input logic signed [DATA_W-1:0] word,
                            input logic [POS_W-1:0] pos);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_TDATA_W - DATA_W - POS_W){1'b0}}, pos, word};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (cmd)
            CMD_APPEND:      if (list_len < DEPTH) list_len++;
            CMD_REMOVE_LAST: if (list_len > 0) list_len--;
            CMD_INSERT:      if (list_len < DEPTH && int'(pos) <= list_len) list_len++;
            default:         if (list_len > 0 && int'(pos) < list_len) list_len--;
        endcase
        if (burst_left <= 1) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end else begin
            burst_left--;
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly positions that fit the current length, some at the boundary,
    // some anywhere in the field.
    function automatic logic [POS_W-1:0] pick_position(input cmd_t cmd);
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return POS_W'($urandom_range(0, 31));
        if (r < 22)
            return POS_W'(list_len);
        if (cmd == CMD_REMOVE_AT && list_len > 0)
            return POS_W'($urandom_range(0, list_len - 1));
        return POS_W'($urandom_range(0, list_len));
    endfunction

    function automatic cmd_t pick_cmd(input mix_t mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:   return (r < 40) ? CMD_APPEND : (r < 75) ? CMD_INSERT :
                               (r < 87) ? CMD_REMOVE_LAST : CMD_REMOVE_AT;
            MIX_SHRINK: return (r < 12) ? CMD_APPEND : (r < 25) ? CMD_INSERT :
                               (r < 60) ? CMD_REMOVE_LAST : CMD_REMOVE_AT;
            default:    return cmd_t'(r % 4);
        endcase
    endfunction

    initial begin : stimulus
        mix_t mix;
        int   mix_left;
        cmd_t cmd;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // empty list, then a few entries with the extreme words
        send_cmd(CMD_REMOVE_LAST, pick_word(), 5'd0);
        send_cmd(CMD_REMOVE_AT,   pick_word(), 5'd31);
        send_cmd(CMD_INSERT,      pick_word(), 5'd1);
        send_cmd(CMD_INSERT,      WORD_MAX,    5'd0);
        send_cmd(CMD_APPEND,      WORD_MIN,    5'd0);
        send_cmd(CMD_INSERT,      -1,          5'd2);  // position equal to length
        send_cmd(CMD_INSERT,      '0,          5'd1);
        send_cmd(CMD_REMOVE_AT,   pick_word(), 5'd4);  // position equal to length
        send_cmd(CMD_REMOVE_AT,   pick_word(), 5'd1);
        send_cmd(CMD_REMOVE_LAST, pick_word(), 5'd0);
        // fill up, then push against the full list
        while (list_len < DEPTH)
            send_cmd(CMD_APPEND, pick_word(), POS_W'($urandom_range(0, 31)));
        send_cmd(CMD_APPEND,    pick_word(), 5'd0);
        send_cmd(CMD_INSERT,    pick_word(), 5'd31);  // full wins over range
        send_cmd(CMD_REMOVE_AT, pick_word(), POS_W'(DEPTH - 1));

        mix      = MIX_SHRINK;
        mix_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (mix_left == 0) begin
                mix      = mix_t'($urandom_range(0, 2));
                mix_left = $urandom_range(20, 60);
            end
            mix_left--;
            cmd = pick_cmd(mix);
            send_cmd(cmd, pick_word(), pick_position(cmd));
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_awaited != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
